[rtl/core/trial_division_primality_test_core_assert.svh]
// Assertion macros for the trial division primality test core
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TDP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdp assertion failed");

// next-cycle implication, checked out of reset
`define TDP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdp assertion failed");

`endif

[rtl/core/tdp_pkg.sv]
// Package: widths, wheel constants and state types of the primality test core
`timescale 1ns / 1ps
`default_nettype none
package tdp_pkg;
	localparam int VALUE_WIDTH = 32;
	localparam int IN_WIDTH    = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	localparam logic [VALUE_WIDTH-1:0] SMALL_PRIME   = VALUE_WIDTH'(3);
	localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(5);
	localparam logic [VALUE_WIDTH-1:0] WHEEL_STEP    = VALUE_WIDTH'(6);
	localparam logic [VALUE_WIDTH-1:0] PAIR_GAP      = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] ONE_VALUE     = VALUE_WIDTH'(1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		PH_THREE = 3'b001,
		PH_LOW   = 3'b010,
		PH_HIGH  = 3'b100
	} phase_t;
endpackage
`default_nettype wire

[rtl/core/trial_division_primality_test_core.sv]
// Top level: trial division primality test over the 6k +/- 1 wheel with a bit-serial divider
//
// One candidate enters per transaction and one is_prime_flag leaves per transaction.
// Values below 2 are not prime, 2 and 3 are prime, other even values are composite; these
// go straight to the hold state. Every other value goes through one restoring divider that
// produces one quotient bit per cycle. The test divides by 3 and then by the pairs d and d+2
// for d = 5, 11, 17, ... while d does not exceed n/d, stopping at the first zero remainder.
// One item is in work at a time; a finished flag waits in its output register, and the next
// candidate is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module trial_division_primality_test_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cand_valid,
	output logic                            cand_stall,
	input  wire logic [tdp_pkg::IN_WIDTH-1:0] candidate,
	output logic                            prime_valid,
	input  wire logic                       prime_stall,
	output logic                            is_prime_flag
);
	import tdp_pkg::*;

	state_t                 state_q;
	phase_t                 phase_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] dsh_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic                   result_q;
	logic                   out_valid_q;
	logic                   out_flag_q;

	logic [63:0]            cand_ext;
	logic [VALUE_WIDTH-1:0] n_init;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   ge;
	logic [VALUE_WIDTH-1:0] rem_next;
	logic [VALUE_WIDTH-1:0] quo_next;
	logic                   cand_acc;
	logic                   out_free;
	logic                   last_bit;

	assign cand_ext = {{(64 - IN_WIDTH){1'b0}}, candidate};
	assign n_init   = cand_ext[VALUE_WIDTH-1:0];

	assign trial    = {rem_q, dsh_q[VALUE_WIDTH-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = ~diff[VALUE_WIDTH];
	assign rem_next = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
	assign quo_next = {quo_q[VALUE_WIDTH-2:0], ge};
	assign last_bit = (cnt_q == '0);

	assign cand_stall    = (state_q != S_IDLE);
	assign cand_acc      = cand_valid & ~cand_stall;
	assign out_free      = ~out_valid_q | ~prime_stall;
	assign prime_valid   = out_valid_q;
	assign is_prime_flag = out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !prime_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cand_acc) begin
						if (n_init <= SMALL_PRIME || !n_init[0]) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (last_bit) begin
						case (phase_q)
							PH_THREE: begin
								if (rem_next == '0) begin
									state_q <= S_HOLD;
								end
							end
							PH_LOW: begin
								if (d_q > quo_next || rem_next == '0) begin
									state_q <= S_HOLD;
								end
							end
							PH_HIGH: begin
								if (rem_next == '0) begin
									state_q <= S_HOLD;
								end
							end
							default: state_q <= S_HOLD;
						endcase
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && out_free) begin
			out_flag_q <= result_q;
		end
		case (state_q)
			S_IDLE: begin
				if (cand_acc) begin
					n_q      <= n_init;
					dsh_q    <= n_init;
					rem_q    <= '0;
					quo_q    <= '0;
					cnt_q    <= CNT_W'(VALUE_WIDTH - 1);
					dvs_q    <= SMALL_PRIME;
					d_q      <= FIRST_DIVISOR;
					phase_q  <= PH_THREE;
					result_q <= (n_init > ONE_VALUE) && (n_init <= SMALL_PRIME);
				end
			end
			S_DIV: begin
				if (!last_bit) begin
					dsh_q <= {dsh_q[VALUE_WIDTH-2:0], 1'b0};
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					dsh_q <= n_q;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CNT_W'(VALUE_WIDTH - 1);
					case (phase_q)
						PH_THREE: begin
							result_q <= 1'b0;
							dvs_q    <= d_q;
							phase_q  <= PH_LOW;
						end
						PH_LOW: begin
							result_q <= (d_q > quo_next);
							dvs_q    <= d_q + PAIR_GAP;
							phase_q  <= PH_HIGH;
						end
						PH_HIGH: begin
							result_q <= 1'b0;
							d_q      <= d_q + WHEEL_STEP;
							dvs_q    <= d_q + WHEEL_STEP;
							phase_q  <= PH_LOW;
						end
						default: phase_q <= PH_THREE;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

`include "trial_division_primality_test_core_assert.svh"

	`TDP_ASSERT_NEXT(a_accept_busy, cand_acc, state_q != S_IDLE)
	`TDP_ASSERT_NEXT(a_hold_delivers, state_q == S_HOLD && out_free, out_valid_q)
	`TDP_ASSERT_NOW(a_rem_below_divisor, state_q == S_DIV, rem_q < dvs_q)
	`TDP_ASSERT_NOW(a_divisor_odd, state_q == S_DIV, dvs_q[0])

endmodule
`default_nettype wire

[bench/trial_division_primality_test_core_checker.sv]
// Checker for the primality test core: predicts the flag of every candidate and compares results
`timescale 1ns / 1ps
module trial_division_primality_test_core_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cand_valid,
	input  wire logic                         cand_stall,
	input  wire logic [tdp_pkg::IN_WIDTH-1:0] candidate,
	input  wire logic                         prime_valid,
	input  wire logic                         prime_stall,
	input  wire logic                         is_prime_flag,
	output int                                mismatches,
	output int                                pending
);
	typedef struct packed {
		logic [tdp_pkg::IN_WIDTH-1:0] value;
		logic                         flag;
	} verdict_t;

	verdict_t awaited_verdicts [$];
	verdict_t oldest;

	function automatic logic prime_by_wheel(input logic [tdp_pkg::IN_WIDTH-1:0] raw);
		longint unsigned width_mask;
		longint unsigned n;
		longint unsigned d;
		width_mask = (tdp_pkg::VALUE_WIDTH >= 64) ? ~64'd0
			: ((64'd1 << tdp_pkg::VALUE_WIDTH) - 64'd1);
		n = 64'(raw) & width_mask;
		if (n < 2)
			return 1'b0;
		if (n <= 64'(tdp_pkg::SMALL_PRIME))
			return 1'b1;
		if (n % 2 == 0 || n % 3 == 0)
			return 1'b0;
		for (d = 64'(tdp_pkg::FIRST_DIVISOR); d <= n / d; d += 64'(tdp_pkg::WHEEL_STEP)) begin
			if (n % d == 0 || n % (d + 64'(tdp_pkg::PAIR_GAP)) == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			mismatches = 0;
			awaited_verdicts.delete();
		end else begin
			if (prime_valid && !prime_stall) begin
				if (awaited_verdicts.size() == 0) begin
					mismatches++;
					$display("%0t: is_prime_flag expected none actual %0b", $time, is_prime_flag);
				end else begin
					oldest = awaited_verdicts.pop_front();
					if (is_prime_flag !== oldest.flag) begin
						mismatches++;
						$display("%0t: candidate %0d is_prime_flag expected %0b actual %0b",
							$time, oldest.value, oldest.flag, is_prime_flag);
					end
				end
			end
			if (cand_valid && !cand_stall)
				awaited_verdicts.push_back('{value: candidate, flag: prime_by_wheel(candidate)});
		end
		pending = awaited_verdicts.size();
	end
endmodule

[bench/tb_trial_division_primality_test_core.sv]
// Testbench top for the primality test core: clock, reset, candidate stimulus and verdict
`timescale 1ns / 1ps
module tb_trial_division_primality_test_core;
	logic                         clk;
	logic                         arst_n;
	logic                         cand_valid;
	logic                         cand_stall;
	logic [tdp_pkg::IN_WIDTH-1:0] candidate;
	logic                         prime_valid;
	logic                         prime_stall;
	logic                         is_prime_flag;
	int                           mismatches;
	int                           pending;
	logic                         calm;
	logic                         sender_gaps_on;
	logic                         long_hold_req;

	logic [31:0] corner_values [25] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9, 32'd25,
		32'd35, 32'd49, 32'd97, 32'd121, 32'd143, 32'd169, 32'd289, 32'd323, 32'd361,
		32'd65521, 32'd65537, 32'd1000003, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFB
	};

	trial_division_primality_test_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cand_valid    (cand_valid),
		.cand_stall    (cand_stall),
		.candidate     (candidate),
		.prime_valid   (prime_valid),
		.prime_stall   (prime_stall),
		.is_prime_flag (is_prime_flag)
	);

	trial_division_primality_test_core_checker flag_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cand_valid    (cand_valid),
		.cand_stall    (cand_stall),
		.candidate     (candidate),
		.prime_valid   (prime_valid),
		.prime_stall   (prime_stall),
		.is_prime_flag (is_prime_flag),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#96_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] pick_candidate();
		logic [31:0] wide;
		logic [31:0] factor;
		wide = $urandom;
		case ($urandom_range(0, 3))
			0: factor = 32'd3;
			1: factor = 32'd5;
			2: factor = 32'd7;
			default: factor = 32'd13;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 4095);
			6, 7: return $urandom_range(0, 32'h000F_FFFF);
			8: return {wide[31:1], 1'b0};
			default: return wide - (wide % factor);
		endcase
	endfunction

	task automatic offer_candidate(input logic [31:0] value);
		@(negedge clk);
		cand_valid = 1'b1;
		candidate  = value;
		do @(posedge clk); while (cand_stall);
	endtask

	task automatic pause_sender();
		if (!calm && sender_gaps_on && $urandom_range(0, 2) == 0) begin
			@(negedge clk);
			cand_valid = 1'b0;
			candidate  = $urandom;
			repeat ($urandom_range(1, 17) - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		cand_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		prime_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				prime_stall = 1'b1;
				repeat ($urandom_range(250, 400)) @(negedge clk);
				long_hold_req = 1'b0;
				prime_stall   = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				prime_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				prime_stall = 1'b0;
			end else begin
				prime_stall = 1'b0;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		cand_valid     = 1'b0;
		candidate      = '0;
		calm           = 1'b0;
		sender_gaps_on = 1'b1;
		long_hold_req  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (corner_values[i]) begin
			offer_candidate(corner_values[i]);
			pause_sender();
		end
		drain_results();

		// hold the output side and keep offering so the core backs up
		long_hold_req = 1'b1;
		repeat (8) offer_candidate($urandom_range(0, 60));
		drain_results();

		for (int i = 0; i < 67; i++) begin
			if (i % 20 == 0)
				sender_gaps_on = $urandom_range(0, 1);
			if (i == 52)
				calm = 1'b1;
			offer_candidate(pick_candidate());
			pause_sender();
		end

		drain_results();
		repeat (100) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
